// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
// Clocked by i_clk; the reset-gated form ignores cycles in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define CVN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CVN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- src/cvn_pkg.sv -----
// Package for the 3x3 normalized convolution block: sequencer states,
// register indexes and fixed widths. No dependencies.
`default_nettype none
package cvn_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UPD,
        ST_MAC,
        ST_SIGN,
        ST_DIV,
        ST_DONE
    } t_state;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOT   = 3'd4;

    localparam logic [13:0] RST_LINE_BYTES = 14'd2520;
    localparam logic [1:0]  RST_CHANNELS   = 2'd1;
    localparam logic [23:0] RST_COEF_TOP   = 24'h01FF00;
    localparam logic [23:0] RST_COEF_MID   = 24'h000100;
    localparam logic [23:0] RST_COEF_BOT   = 24'h00FF01;

    localparam int ACC_W = 20;
    localparam int SUM_W = 12;
    localparam int DIV_STEPS = ACC_W;
    localparam int POS_W = 17;

endpackage
`default_nettype wire

// ----- src/cvn_in_if.sv -----
// Input channel: one image byte per beat plus the frame start flag.
// Standalone, no dependencies.
`default_nettype none
interface cvn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_in;
    logic       frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface
`default_nettype wire

// ----- src/cvn_out_if.sv -----
// Result channel: filtered byte, change flag and centre position per beat.
// Standalone, no dependencies.
`default_nettype none
interface cvn_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_out;
    logic        changed;
    logic [15:0] centre_row;
    logic [12:0] centre_col;

    modport source (output valid, output pixel_out, output changed, output centre_row,
                    output centre_col, input ready);
    modport sink   (input valid, input pixel_out, input changed, input centre_row,
                    input centre_col, output ready);
endinterface
`default_nettype wire

// ----- src/cvn_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module cvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/conv3x3_normalized_wrap.sv -----
// Top level of the 3x3 normalized convolution: sequencer, window, shared
// multiply-accumulate and bit-serial divider. Uses cvn_pkg, cvn_in_if,
// cvn_out_if, cvn_ram and assert_macros.svh.
//
//   channel   dir  beat carries
//   i_pix     in   pixel_in, frame_start
//   o_res     out  pixel_out, changed, centre_row, centre_col
//   i_cfg_*   in   register write (index, data), always taken
//
// Steps: an item with a result goes through accept, line store read, update,
// multiply-accumulate (one per tap), sign setup, restoring divider (one quotient
// bit each step, skipped when the weights sum to zero) and output load before the
// next accept; an item with no result returns to accept straight after update.
// Reset (synchronous, active low) clears the sequencer, counters, window and
// registers; line stores are not cleared. A stalled result is held in the
// output register while the next item is taken; a second result waits in the
// output load state until the register frees up.
`default_nettype none
`include "assert_macros.svh"
module conv3x3_normalized_wrap #(
    parameter int MAX_LINE = 8192
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    cvn_in_if.sink                               i_pix,
    cvn_out_if.source                            o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [cvn_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cvn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int AW = $clog2(MAX_LINE);
    localparam int PW = cvn_pkg::POS_W;
    localparam int KW = $clog2(cvn_pkg::DIV_STEPS);

    // configuration
    logic [13:0] r_line_bytes;
    logic [1:0]  r_channels;
    logic [23:0] r_coef [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= cvn_pkg::RST_LINE_BYTES;
            r_channels   <= cvn_pkg::RST_CHANNELS;
            r_coef[0]    <= cvn_pkg::RST_COEF_TOP;
            r_coef[1]    <= cvn_pkg::RST_COEF_MID;
            r_coef[2]    <= cvn_pkg::RST_COEF_BOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cvn_pkg::CFG_LINE_BYTES: r_line_bytes <= i_cfg_data[13:0];
                cvn_pkg::CFG_CHANNELS:   r_channels   <= i_cfg_data[1:0];
                cvn_pkg::CFG_COEF_TOP:   r_coef[0]    <= i_cfg_data;
                cvn_pkg::CFG_COEF_MID:   r_coef[1]    <= i_cfg_data;
                cvn_pkg::CFG_COEF_BOT:   r_coef[2]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [1:0]    ch;
    logic [PW-1:0] len;
    always_comb begin
        ch = (r_channels == 2'd0) ? 2'd1 : r_channels;
        if ({3'b0, r_line_bytes} < PW'(3)) begin
            len = PW'(3);
        end else if ({3'b0, r_line_bytes} > PW'(MAX_LINE)) begin
            len = PW'(MAX_LINE);
        end else begin
            len = {3'b0, r_line_bytes};
        end
    end

    // sequencer
    cvn_pkg::t_state r_state, n_state;
    logic fire, out_free;
    logic ld_out, ram_we, mac_last;
    logic [KW-1:0] r_k;
    logic [1:0] r_rr, r_cc;
    logic r_prod, r_zero;

    assign fire     = i_pix.valid && i_pix.ready;
    assign out_free = !o_res.valid || o_res.ready;
    assign mac_last = (r_rr == 2'd2) && (r_cc == 2'd2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cvn_pkg::ST_IDLE: if (fire) n_state = cvn_pkg::ST_LOAD;
            cvn_pkg::ST_LOAD: n_state = cvn_pkg::ST_UPD;
            cvn_pkg::ST_UPD:  n_state = r_prod ? cvn_pkg::ST_MAC : cvn_pkg::ST_IDLE;
            cvn_pkg::ST_MAC:  if (mac_last) n_state = cvn_pkg::ST_SIGN;
            cvn_pkg::ST_SIGN: n_state = r_zero ? cvn_pkg::ST_DONE : cvn_pkg::ST_DIV;
            cvn_pkg::ST_DIV:  if (r_k == KW'(cvn_pkg::DIV_STEPS - 1)) n_state = cvn_pkg::ST_DONE;
            cvn_pkg::ST_DONE: if (out_free) n_state = cvn_pkg::ST_IDLE;
            default:          n_state = cvn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        i_pix.ready = (r_state == cvn_pkg::ST_IDLE);
        ram_we      = (r_state == cvn_pkg::ST_UPD);
        ld_out      = (r_state == cvn_pkg::ST_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= cvn_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // position and accept
    logic [AW-1:0] r_col, r_idx;
    logic [15:0]   r_row, r_crow;
    logic [12:0]   r_ccol;
    logic [7:0]    r_px;
    logic [AW-1:0] col_cur;
    logic [15:0]   row_cur;
    logic [PW-1:0] col_ext;

    always_comb begin
        col_cur = i_pix.frame_start ? '0 : r_col;
        row_cur = i_pix.frame_start ? '0 : r_row;
        col_ext = PW'(col_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prod <= 1'b0;
        end else if (fire) begin
            r_idx  <= col_cur;
            r_px   <= i_pix.pixel_in;
            r_crow <= row_cur - 16'd1;
            r_ccol <= 13'(col_ext - PW'(ch));
            r_prod <= (row_cur >= 16'd2) && (col_ext >= PW'({ch, 1'b0}))
                      && (col_ext < len);
            if (col_ext + PW'(1) >= len) begin
                r_col <= '0;
                if (row_cur != 16'hFFFF) r_row <= row_cur + 16'd1;
                else                     r_row <= row_cur;
            end else begin
                r_col <= AW'(col_ext + PW'(1));
                r_row <= row_cur;
            end
        end
    end

    // line stores
    logic [7:0] up_q, lo_q;

    cvn_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_upper (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (lo_q),
        .i_raddr (r_idx),
        .o_rdata (up_q)
    );

    cvn_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_lower (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_px),
        .i_raddr (r_idx),
        .o_rdata (lo_q)
    );

    // window: row 0 top, tap 0 newest
    logic [7:0] r_win [3][7];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 7; k++) r_win[r][k] <= 8'd0;
            end
        end else if (ram_we) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 6; k > 0; k--) r_win[r][k] <= r_win[r][k-1];
            end
            r_win[0][0] <= up_q;
            r_win[1][0] <= lo_q;
            r_win[2][0] <= r_px;
        end
    end

    // shared multiply-accumulate, one tap per cycle
    logic [2:0]  tap_idx;
    logic [7:0]  tap;
    logic signed [7:0]  w;
    logic signed [16:0] prod;
    logic signed [cvn_pkg::ACC_W-1:0] r_acc;
    logic signed [cvn_pkg::SUM_W-1:0] r_wsum;

    always_comb begin
        tap_idx = 3'((3'd2 - {1'b0, r_cc}) * {1'b0, ch});
        tap     = r_win[r_rr][tap_idx];
        w       = $signed(r_coef[r_rr][{r_cc, 3'b000} +: 8]);
        prod    = w * $signed({1'b0, tap});
    end

    // divider
    logic [cvn_pkg::ACC_W-1:0] r_quo;
    logic [cvn_pkg::SUM_W-1:0] r_rem, r_den;
    logic r_neg;
    logic [cvn_pkg::SUM_W:0] trial;

    assign trial = {r_rem, r_quo[cvn_pkg::ACC_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rr   <= '0;
            r_cc   <= '0;
            r_k    <= '0;
            r_zero <= 1'b0;
        end else begin
            unique case (r_state)
                cvn_pkg::ST_UPD: begin
                    r_rr   <= '0;
                    r_cc   <= '0;
                    r_acc  <= '0;
                    r_wsum <= '0;
                end
                cvn_pkg::ST_MAC: begin
                    r_acc  <= r_acc + cvn_pkg::ACC_W'(prod);
                    r_wsum <= r_wsum + cvn_pkg::SUM_W'(w);
                    if (r_cc == 2'd2) begin
                        r_cc <= '0;
                        r_rr <= r_rr + 2'd1;
                    end else begin
                        r_cc <= r_cc + 2'd1;
                    end
                    r_zero <= mac_last && ((r_wsum + cvn_pkg::SUM_W'(w)) == '0);
                end
                cvn_pkg::ST_SIGN: begin
                    r_quo <= r_acc[cvn_pkg::ACC_W-1] ? cvn_pkg::ACC_W'(-r_acc)
                                                     : cvn_pkg::ACC_W'(r_acc);
                    r_den <= r_wsum[cvn_pkg::SUM_W-1] ? cvn_pkg::SUM_W'(-r_wsum)
                                                      : cvn_pkg::SUM_W'(r_wsum);
                    r_neg <= r_acc[cvn_pkg::ACC_W-1] ^ r_wsum[cvn_pkg::SUM_W-1];
                    r_rem <= '0;
                    r_k   <= '0;
                end
                cvn_pkg::ST_DIV: begin
                    r_k <= r_k + KW'(1);
                    if (trial >= {1'b0, r_den}) begin
                        r_rem <= cvn_pkg::SUM_W'(trial - {1'b0, r_den});
                        r_quo <= {r_quo[cvn_pkg::ACC_W-2:0], 1'b1};
                    end else begin
                        r_rem <= trial[cvn_pkg::SUM_W-1:0];
                        r_quo <= {r_quo[cvn_pkg::ACC_W-2:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
    end

    // result: ceiling of the quotient, or the raw sum when the weights sum to zero, wrapped to 8 bits
    logic [7:0] res;
    always_comb begin
        if (r_zero)     res = r_acc[7:0];
        else if (r_neg) res = 8'(~r_quo[7:0] + 8'd1);
        else            res = r_quo[7:0] + {7'd0, r_rem != '0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else if (ld_out) begin
            o_res.valid      <= 1'b1;
            o_res.pixel_out  <= res;
            o_res.changed    <= res != r_win[1][{1'b0, ch}];
            o_res.centre_row <= r_crow;
            o_res.centre_col <= r_ccol;
        end else if (o_res.ready) begin
            o_res.valid <= 1'b0;
        end
    end

    `CVN_ASSERT(a_fire_loads, fire |=> r_state == cvn_pkg::ST_LOAD, "accept did not start a read")
    `CVN_ASSERT(a_rem_bound, r_state == cvn_pkg::ST_DIV |-> r_rem < r_den, "divider remainder out of range")
    `CVN_ASSERT(a_done_path, ld_out |-> r_prod, "result loaded for an item without one")
    `CVN_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> r_state == cvn_pkg::ST_IDLE && !o_res.valid, "reset did not idle")

endmodule
`default_nettype wire
